// ===== hdl/sba_pkg.sv =====
// ----------------------------------------------------------------------------
// sba_pkg: shared types and constants of the swap block allocator
// Field widths, request and status codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package sba_pkg;

  localparam int OP_W       = 2;
  localparam int PID_W      = 4;
  localparam int PAGE_W     = 8;
  localparam int STAT_W     = 2;
  localparam int BN_W       = 10;
  localparam int CFG_W      = 11;
  localparam int CFG_RESET  = 1024;

  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_NOMAP   = 2'd2
  } sba_status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PID_CHK,
    S_PID_MOD,
    S_PAGE_CHK,
    S_PAGE_MOD,
    S_INDEX,
    S_MAP_RD,
    S_DISPATCH,
    S_LAST_MOD,
    S_SCAN_INIT,
    S_SCAN,
    S_RESP
  } sba_state_t;

endpackage

`default_nettype wire

// ===== hdl/sba_ram.sv =====
// ----------------------------------------------------------------------------
// sba_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/sba_rem.sv =====
// ----------------------------------------------------------------------------
// sba_rem: iterative remainder unit
// Restoring shift-subtract, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sba_rem #(
  parameter int DW = 10,
  parameter int VW = 11
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic      [VW-1:0] rem
);

  localparam int SW = (DW > 1) ? $clog2(DW) : 1;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [DW-1:0] dvd_r, dvd_nxt;
  logic [VW-1:0] div_r, div_nxt;
  logic [VW-1:0] acc_r, acc_nxt;
  logic [VW:0]   sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    acc_nxt  = acc_r;
    sh       = {acc_r, dvd_r[DW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      acc_nxt  = '0;
    end else if (busy_r) begin
      // shift in next bit, subtract when it fits
      if (sh >= {1'b0, div_r}) begin
        acc_nxt = VW'(sh - {1'b0, div_r});
      end else begin
        acc_nxt = sh[VW-1:0];
      end
      dvd_nxt  = dvd_r << 1;
      step_nxt = step_r + 1'b1;
      if (step_r == SW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    dvd_r  <= dvd_nxt;
    div_r  <= div_nxt;
    acc_r  <= acc_nxt;
  end

  assign done = done_r;
  assign rem  = acc_r;

endmodule

`default_nettype wire

// ===== hdl/swap_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// swap_block_allocator_top: next-fit swap block allocator
// Page-to-block map and block ownership bits in RAM, sequenced over one
// shared remainder unit and a one-block-per-cycle next-fit scan.
// ----------------------------------------------------------------------------
// Reset: a clearing pass over max(NUM_BLOCKS, NUM_PROCS*PAGES_PER_PROC) addresses
//   (4096 at defaults) zeroes both RAMs; no transfer is taken meanwhile.
// Sequencing: one request at a time. Process and page indexes that are out of
//   range are each reduced through the remainder unit first.
// Allocate adds a next-fit scan (one owned bit read per cycle), plus a reduction
//   of the last allocated block when it lies beyond the wrap point.
// Overlap: the next request is taken once the result is registered and the
//   sequencer is back in idle; a finished result waits in the output register
//   while the next request proceeds.
// ----------------------------------------------------------------------------
`default_nettype none

module swap_block_allocator_top #(
  parameter int NUM_BLOCKS     = 1024,
  parameter int NUM_PROCS      = 16,
  parameter int PAGES_PER_PROC = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // request channel
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [sba_pkg::OP_W-1:0]   in_opcode,
  input  wire logic [sba_pkg::PID_W-1:0]  in_process_id,
  input  wire logic [sba_pkg::PAGE_W-1:0] in_page_number,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [sba_pkg::STAT_W-1:0] out_status,
  output logic      [sba_pkg::BN_W-1:0]   out_block_number,
  // blocks_in_use register
  input  wire logic                       cfg_wr_en,
  input  wire logic [sba_pkg::CFG_W-1:0]  cfg_wr_data
);

  import sba_pkg::*;

  // --------------------------------------------------------------------------
  // Derived sizes
  // --------------------------------------------------------------------------
  localparam int NUM_MAP = NUM_PROCS * PAGES_PER_PROC;
  localparam int BLK_W   = $clog2(NUM_BLOCKS);
  localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);
  localparam int IDX_W   = (NUM_MAP > 1) ? $clog2(NUM_MAP) : 1;
  localparam int MAP_W   = BLK_W + 1;
  localparam int CLR_N   = (NUM_BLOCKS > NUM_MAP) ? NUM_BLOCKS : NUM_MAP;
  localparam int CLR_W   = $clog2(CLR_N);
  localparam int EW      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int XW      = (BLK_W > BN_W) ? BLK_W : BN_W;
  localparam int DW      = (BLK_W > PAGE_W) ? BLK_W : PAGE_W;
  localparam int PRW     = $clog2(NUM_PROCS + 1);
  localparam int PGW     = $clog2(PAGES_PER_PROC + 1);
  localparam int VW0     = (PRW > PGW) ? PRW : PGW;
  localparam int VW      = (CNT_W > VW0) ? CNT_W : VW0;
  // last block after reset: effective reset count minus one
  localparam int LAST_RST = ((NUM_BLOCKS < CFG_RESET) ? NUM_BLOCKS : CFG_RESET) - 1;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  sba_state_t         state_r, state_nxt;
  logic [CLR_W-1:0]   clr_ptr_r, clr_ptr_nxt;
  logic [CFG_W-1:0]   biu_r, biu_nxt;
  logic [BLK_W-1:0]   last_r, last_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               chk_vld_r, chk_vld_nxt;

  logic [OP_W-1:0]    op_r, op_nxt;
  logic [PID_W-1:0]   pid_r, pid_nxt;
  logic [PAGE_W-1:0]  page_r, page_nxt;
  logic [VW-1:0]      p_r, p_nxt;
  logic [VW-1:0]      g_r, g_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [BLK_W-1:0]   start_r, start_nxt;
  logic [BLK_W-1:0]   scan_ptr_r, scan_ptr_nxt;
  logic [CNT_W-1:0]   iss_cnt_r, iss_cnt_nxt;
  logic [BLK_W-1:0]   chk_ptr_r, chk_ptr_nxt;
  logic               chk_last_r, chk_last_nxt;
  sba_status_t        res_stat_r, res_stat_nxt;
  logic [BLK_W-1:0]   res_blk_r, res_blk_nxt;
  logic [STAT_W-1:0]  out_stat_r, out_stat_nxt;
  logic [BN_W-1:0]    out_bn_r, out_bn_nxt;

  // --------------------------------------------------------------------------
  // Effective block count: register clamped to 1..NUM_BLOCKS
  // --------------------------------------------------------------------------
  logic [EW-1:0]    biu_ext;
  logic [EW-1:0]    cnt_ext;
  logic [CNT_W-1:0] cnt;

  always_comb begin
    biu_ext = EW'(biu_r);
    if (biu_ext == '0) begin
      cnt_ext = EW'(1);
    end else if (biu_ext > EW'(NUM_BLOCKS)) begin
      cnt_ext = EW'(NUM_BLOCKS);
    end else begin
      cnt_ext = biu_ext;
    end
    cnt = cnt_ext[CNT_W-1:0];
  end

  // --------------------------------------------------------------------------
  // Shared remainder unit: process index, page index, scan start
  // --------------------------------------------------------------------------
  logic          rem_start;
  logic [DW-1:0] rem_dvd;
  logic [VW-1:0] rem_div;
  logic          rem_done;
  logic [VW-1:0] rem_res;

  sba_rem #(
    .DW (DW),
    .VW (VW)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (rem_dvd),
    .divisor  (rem_div),
    .done     (rem_done),
    .rem      (rem_res)
  );

  // --------------------------------------------------------------------------
  // Ownership bits and page map
  // --------------------------------------------------------------------------
  logic             own_we;
  logic [BLK_W-1:0] own_waddr;
  logic [0:0]       own_wdata;
  logic [0:0]       own_rdata;

  logic             map_we;
  logic [IDX_W-1:0] map_waddr;
  logic [MAP_W-1:0] map_wdata;
  logic [MAP_W-1:0] map_rdata;

  sba_ram #(
    .WIDTH (1),
    .DEPTH (NUM_BLOCKS)
  ) u_own_ram (
    .clk   (clk),
    .we    (own_we),
    .waddr (own_waddr),
    .wdata (own_wdata),
    .raddr (scan_ptr_r),
    .rdata (own_rdata)
  );

  sba_ram #(
    .WIDTH (MAP_W),
    .DEPTH (NUM_MAP)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (idx_r),
    .rdata (map_rdata)
  );

  // map entry: valid bit on top, block below
  logic             ent_vld;
  logic [BLK_W-1:0] ent_blk;
  assign ent_vld = map_rdata[BLK_W];
  assign ent_blk = map_rdata[BLK_W-1:0];

  // next-fit pointer step with wrap at the effective count
  logic [BLK_W-1:0] ptr_base;
  logic [CNT_W-1:0] ptr_inc;
  logic [BLK_W-1:0] ptr_next;

  always_comb begin
    ptr_base = (state_r == S_SCAN_INIT) ? start_r : scan_ptr_r;
    ptr_inc  = CNT_W'(ptr_base) + 1'b1;
    ptr_next = (ptr_inc == cnt) ? '0 : ptr_inc[BLK_W-1:0];
  end

  // result block number onto the 10-bit field
  logic [XW-1:0] res_blk_ext;
  assign res_blk_ext = XW'(res_blk_r);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    clr_ptr_nxt  = clr_ptr_r;
    biu_nxt      = cfg_wr_en ? cfg_wr_data : biu_r;
    last_nxt     = last_r;
    chk_vld_nxt  = 1'b0;
    op_nxt       = op_r;
    pid_nxt      = pid_r;
    page_nxt     = page_r;
    p_nxt        = p_r;
    g_nxt        = g_r;
    idx_nxt      = idx_r;
    start_nxt    = start_r;
    scan_ptr_nxt = scan_ptr_r;
    iss_cnt_nxt  = iss_cnt_r;
    chk_ptr_nxt  = chk_ptr_r;
    chk_last_nxt = chk_last_r;
    res_stat_nxt = res_stat_r;
    res_blk_nxt  = res_blk_r;

    rem_start = 1'b0;
    rem_dvd   = DW'(pid_r);
    rem_div   = VW'(NUM_PROCS);

    own_we    = 1'b0;
    own_waddr = chk_ptr_r;
    own_wdata = 1'b0;
    map_we    = 1'b0;
    map_waddr = idx_r;
    map_wdata = '0;

    // output register: drains on transfer, reloaded from RESP
    out_valid_nxt = out_valid_r & ~out_ready;
    out_stat_nxt  = out_stat_r;
    out_bn_nxt    = out_bn_r;

    unique case (state_r)
      S_CLEAR: begin
        own_we    = (32'(clr_ptr_r) < NUM_BLOCKS);
        own_waddr = clr_ptr_r[BLK_W-1:0];
        map_we    = (32'(clr_ptr_r) < NUM_MAP);
        map_waddr = clr_ptr_r[IDX_W-1:0];
        clr_ptr_nxt = clr_ptr_r + 1'b1;
        if (clr_ptr_r == CLR_W'(CLR_N - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode;
          pid_nxt   = in_process_id;
          page_nxt  = in_page_number;
          state_nxt = S_PID_CHK;
        end
      end

      S_PID_CHK: begin
        if (32'(pid_r) < NUM_PROCS) begin
          p_nxt     = VW'(pid_r);
          state_nxt = S_PAGE_CHK;
        end else begin
          rem_start = 1'b1;
          state_nxt = S_PID_MOD;
        end
      end

      S_PID_MOD: begin
        if (rem_done) begin
          p_nxt     = rem_res;
          state_nxt = S_PAGE_CHK;
        end
      end

      S_PAGE_CHK: begin
        rem_dvd = DW'(page_r);
        rem_div = VW'(PAGES_PER_PROC);
        if (32'(page_r) < PAGES_PER_PROC) begin
          g_nxt     = VW'(page_r);
          state_nxt = S_INDEX;
        end else begin
          rem_start = 1'b1;
          state_nxt = S_PAGE_MOD;
        end
      end

      S_PAGE_MOD: begin
        if (rem_done) begin
          g_nxt     = rem_res;
          state_nxt = S_INDEX;
        end
      end

      S_INDEX: begin
        idx_nxt   = IDX_W'(32'(p_r) * PAGES_PER_PROC + 32'(g_r));
        state_nxt = S_MAP_RD;
      end

      S_MAP_RD: begin
        // map read of idx_r lands next cycle
        state_nxt = S_DISPATCH;
      end

      S_DISPATCH: begin
        rem_dvd = DW'(last_r);
        rem_div = VW'(cnt);
        unique case (op_r)
          OP_ALLOC: begin
            if (CNT_W'(last_r) < cnt) begin
              start_nxt = last_r;
              state_nxt = S_SCAN_INIT;
            end else begin
              rem_start = 1'b1;
              state_nxt = S_LAST_MOD;
            end
          end
          OP_FREE: begin
            if (ent_vld) begin
              own_we       = 1'b1;
              own_waddr    = ent_blk;
              own_wdata    = 1'b0;
              map_we       = 1'b1;
              map_wdata    = '0;
              res_stat_nxt = STAT_OK;
              res_blk_nxt  = ent_blk;
            end else begin
              res_stat_nxt = STAT_NOMAP;
              res_blk_nxt  = '0;
            end
            state_nxt = S_RESP;
          end
          default: begin
            // lookup, unused code included
            if (ent_vld) begin
              res_stat_nxt = STAT_OK;
              res_blk_nxt  = ent_blk;
            end else begin
              res_stat_nxt = STAT_NOMAP;
              res_blk_nxt  = '0;
            end
            state_nxt = S_RESP;
          end
        endcase
      end

      S_LAST_MOD: begin
        if (rem_done) begin
          start_nxt = rem_res[BLK_W-1:0];
          state_nxt = S_SCAN_INIT;
        end
      end

      S_SCAN_INIT: begin
        scan_ptr_nxt = ptr_next;
        iss_cnt_nxt  = '0;
        state_nxt    = S_SCAN;
      end

      S_SCAN: begin
        // issue one owned-bit read per cycle, check the one from last cycle
        if (iss_cnt_r != cnt) begin
          chk_vld_nxt  = 1'b1;
          chk_ptr_nxt  = scan_ptr_r;
          chk_last_nxt = ((iss_cnt_r + 1'b1) == cnt);
          scan_ptr_nxt = ptr_next;
          iss_cnt_nxt  = iss_cnt_r + 1'b1;
        end
        if (chk_vld_r && !own_rdata[0]) begin
          chk_vld_nxt  = 1'b0;
          own_we       = 1'b1;
          own_waddr    = chk_ptr_r;
          own_wdata    = 1'b1;
          map_we       = 1'b1;
          map_wdata    = {1'b1, chk_ptr_r};
          last_nxt     = chk_ptr_r;
          res_stat_nxt = STAT_OK;
          res_blk_nxt  = chk_ptr_r;
          state_nxt    = S_RESP;
        end else if (chk_vld_r && chk_last_r) begin
          chk_vld_nxt  = 1'b0;
          res_stat_nxt = STAT_NOSPACE;
          res_blk_nxt  = '0;
          state_nxt    = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = res_stat_r;
          out_bn_nxt    = res_blk_ext[BN_W-1:0];
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_ptr_r   <= '0;
      biu_r       <= CFG_W'(CFG_RESET);
      last_r      <= BLK_W'(LAST_RST);
      out_valid_r <= 1'b0;
      chk_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_ptr_r   <= clr_ptr_nxt;
      biu_r       <= biu_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      chk_vld_r   <= chk_vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    pid_r      <= pid_nxt;
    page_r     <= page_nxt;
    p_r        <= p_nxt;
    g_r        <= g_nxt;
    idx_r      <= idx_nxt;
    start_r    <= start_nxt;
    scan_ptr_r <= scan_ptr_nxt;
    iss_cnt_r  <= iss_cnt_nxt;
    chk_ptr_r  <= chk_ptr_nxt;
    chk_last_r <= chk_last_nxt;
    res_stat_r <= res_stat_nxt;
    res_blk_r  <= res_blk_nxt;
    out_stat_r <= out_stat_nxt;
    out_bn_r   <= out_bn_nxt;
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_stat_r;
  assign out_block_number = out_bn_r;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for swap_block_allocator_top
// Drives allocate/free/lookup requests with random idling on both channels.
// Every result is checked against a next-fit allocator kept in step with
// the requests accepted. blocks_in_use is rewritten between phases,
// including values below 1 and above the block count.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sba_pkg::*;

  // sizes of the block under test (its default parameters)
  localparam int SWAP_BLOCKS = 1024;
  localparam int PROCS       = 16;
  localparam int PAGES       = 256;

  // opcode 3 has no name in the package; the block treats it as a lookup
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  // clearing pass + worst case per request (full scan, both index
  // reductions, sender gap, receiver stall), times three
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int DRAIN_WAIT  = 40;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    sba_status_t       status;
    logic [BN_W-1:0]   block;
  } swap_result_t;

  // --------------------------------------------------------------------------
  // Next-fit allocator mirror plus queue of results still owed by the block
  // --------------------------------------------------------------------------
  class swap_alloc_scoreboard;
    bit                owned [SWAP_BLOCKS];
    bit                page_mapped [PROCS*PAGES];
    bit [BN_W-1:0]     page_block [PROCS*PAGES];
    bit [CFG_W-1:0]    blocks_in_use;
    bit [BN_W-1:0]     last_block;
    int                mapped_pages[$];   // page indexes currently mapped
    swap_result_t      owed_results[$];
    int                errors;
    int                n_checked;
    int                n_granted;
    int                n_disk_full;
    int                n_unmapped;

    function new();
      blocks_in_use = CFG_W'(CFG_RESET);
      last_block    = BN_W'(span() - 1);
    endfunction

    // search width: zero acts as one, above the block count saturates
    function int span();
      int cnt;
      cnt = int'(blocks_in_use);
      if (cnt < 1) cnt = 1;
      if (cnt > SWAP_BLOCKS) cnt = SWAP_BLOCKS;
      return cnt;
    endfunction

    function void set_blocks(logic [CFG_W-1:0] value);
      blocks_in_use = value;
    endfunction

    function void unlist_page(int idx);
      for (int j = 0; j < mapped_pages.size(); j++) begin
        if (mapped_pages[j] == idx) begin
          mapped_pages.delete(j);
          break;
        end
      end
    endfunction

    // one accepted request -> one owed result
    function void note_request(logic [OP_W-1:0] op, logic [PID_W-1:0] pid,
                               logic [PAGE_W-1:0] page);
      int           idx;
      int           cnt;
      int           start;
      int           slot;
      bit           found;
      swap_result_t res;
      idx        = (int'(pid) % PROCS) * PAGES + (int'(page) % PAGES);
      res.status = STAT_OK;
      res.block  = '0;
      case (op)
        OP_ALLOC: begin
          cnt   = span();
          start = int'(last_block) % cnt;
          found = 1'b0;
          for (int k = 1; k <= cnt && !found; k++) begin
            slot = (start + k) % cnt;
            if (!owned[slot]) begin
              found     = 1'b1;
              res.block = BN_W'(slot);
            end
          end
          if (found) begin
            // remapping a mapped page leaves its old block owned
            owned[res.block] = 1'b1;
            last_block       = res.block;
            if (!page_mapped[idx]) mapped_pages.push_back(idx);
            page_mapped[idx] = 1'b1;
            page_block[idx]  = res.block;
          end else begin
            res.status = STAT_NOSPACE;
          end
        end
        OP_FREE: begin
          if (page_mapped[idx]) begin
            res.block        = page_block[idx];
            owned[res.block] = 1'b0;
            page_mapped[idx] = 1'b0;
            page_block[idx]  = '0;
            unlist_page(idx);
          end else begin
            res.status = STAT_NOMAP;
          end
        end
        default: begin
          if (page_mapped[idx]) res.block = page_block[idx];
          else res.status = STAT_NOMAP;
        end
      endcase
      owed_results.push_back(res);
    endfunction

    function void flag(string what, int want, int got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    endfunction

    function void check_result(logic [STAT_W-1:0] status, logic [BN_W-1:0] block);
      swap_result_t want;
      if (owed_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result status %0d block %0d with nothing owed, expected none",
                   $time, status, block);
        return;
      end
      want = owed_results.pop_front();
      n_checked++;
      case (want.status)
        STAT_OK:      n_granted++;
        STAT_NOSPACE: n_disk_full++;
        default:      n_unmapped++;
      endcase
      if (status !== want.status) flag("status", want.status, status);
      if (block !== want.block) flag("block_number", want.block, block);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block under test
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [OP_W-1:0]     in_opcode;
  logic [PID_W-1:0]    in_process_id;
  logic [PAGE_W-1:0]   in_page_number;
  logic                out_valid;
  logic                out_ready;
  logic [STAT_W-1:0]   out_status;
  logic [BN_W-1:0]     out_block_number;
  logic                cfg_wr_en;
  logic [CFG_W-1:0]    cfg_wr_data;

  swap_block_allocator_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_process_id    (in_process_id),
    .in_page_number   (in_page_number),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_block_number (out_block_number),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  swap_alloc_scoreboard sb = new();

  int cycle_count;
  int n_settings;
  bit tx_quiet;   // sender runs back to back while set
  bit rx_quiet;   // receiver never stalls while set

  // --------------------------------------------------------------------------
  // Watchdog: a hung handshake ends the run as a failure
  // --------------------------------------------------------------------------
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped at cycle limit %0d, %0d results still owed",
             CYCLE_LIMIT, sb.owed_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Request side. All tasks return just after a rising edge; inputs change
  // only by nonblocking assignment there, and the handshake is sampled as
  // the pre-edge values seen right after the edge.
  // --------------------------------------------------------------------------
  task automatic send_request(logic [OP_W-1:0] op, logic [PID_W-1:0] pid,
                              logic [PAGE_W-1:0] page);
    int gap;
    if ($urandom_range(0, 29) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 19);
    // valid stays up across back-to-back transfers: only lower it on a gap
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_process_id  <= pid;
    in_page_number <= page;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, pid, page);
  endtask

  // register write only with the block drained: every request yields a
  // result, so an empty owed queue means the block is idle
  task automatic write_blocks(logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_blocks(value);
    n_settings++;
  endtask

  // mostly a page that is mapped right now, else any page
  task automatic pick_page(int mapped_pct, output logic [PID_W-1:0] pid,
                           output logic [PAGE_W-1:0] page);
    int idx;
    if (sb.mapped_pages.size() > 0 && $urandom_range(0, 99) < mapped_pct) begin
      idx  = sb.mapped_pages[$urandom_range(0, sb.mapped_pages.size() - 1)];
      pid  = PID_W'(idx / PAGES);
      page = PAGE_W'(idx % PAGES);
    end else begin
      pid  = PID_W'($urandom_range(0, PROCS - 1));
      page = PAGE_W'($urandom_range(0, PAGES - 1));
    end
  endtask

  task automatic random_request(int alloc_pct);
    logic [OP_W-1:0]   op;
    logic [PID_W-1:0]  pid;
    logic [PAGE_W-1:0] page;
    int                roll;
    if ($urandom_range(0, 99) < alloc_pct) begin
      // allocations go mostly to fresh pages; a few remap a live one
      op = OP_ALLOC;
      pick_page(10, pid, page);
    end else begin
      pick_page(85, pid, page);
      roll = $urandom_range(0, 99);
      if (roll < 55) op = OP_FREE;
      else if (roll < 90) op = OP_LOOKUP;
      else op = OP_SPARE;
    end
    send_request(op, pid, page);
  endtask

  task automatic run_phase(logic [CFG_W-1:0] blocks, int items, int alloc_pct);
    write_blocks(blocks);
    for (int n = 0; n < items; n++) random_request(alloc_pct);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall before each transfer, then wait for valid
  // --------------------------------------------------------------------------
  task automatic drain_results();
    int stall;
    forever begin
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
      stall = rx_quiet ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_status, out_block_number);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = OP_LOOKUP;
    in_process_id  = '0;
    in_page_number = '0;
    out_ready      = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    n_settings     = 0;
    tx_quiet       = 1'b0;
    rx_quiet       = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // receiver starts only once outputs are out of reset
    fork
      drain_results();
    join_none

    // Directed part, reset setting of 1024 blocks. The block's clearing
    // pass holds in_ready low first; the handshake simply waits it out.
    send_request(OP_LOOKUP, '0, '0);          // lookup, nothing mapped
    send_request(OP_FREE, 4'd15, 8'd255);     // free, nothing mapped
    send_request(OP_SPARE, 4'd7, 8'd128);     // opcode 3 behaves as lookup
    send_request(OP_ALLOC, '0, '0);           // search wraps from last block to 0
    send_request(OP_ALLOC, 4'd15, 8'd255);
    send_request(OP_LOOKUP, 4'd15, 8'd255);
    send_request(OP_SPARE, '0, '0);
    send_request(OP_ALLOC, '0, '0);           // remap: old block stays owned
    send_request(OP_FREE, '0, '0);
    send_request(OP_FREE, '0, '0);            // second free finds no mapping
    send_request(OP_LOOKUP, '0, '0);
    // zero acts as one block, and the last block handed out lies past it
    write_blocks('0);
    send_request(OP_ALLOC, 4'd1, 8'd1);       // only block is the leaked one
    write_blocks(11'd2);
    send_request(OP_ALLOC, 4'd1, 8'd1);       // both blocks owned: disk full
    send_request(OP_FREE, 4'd15, 8'd255);
    send_request(OP_ALLOC, 4'd1, 8'd1);       // reuses the freed block
    send_request(OP_LOOKUP, 4'd1, 8'd1);
    // all ones saturates at the block count
    write_blocks(11'd2047);
    send_request(OP_ALLOC, 4'd8, 8'd64);
    send_request(OP_ALLOC, 4'd15, '0);

    // Random phases over several disk sizes: small ones run full and churn
    // through free/allocate, large ones exercise long next-fit searches.
    run_phase(11'd1024, 200, 55);
    run_phase(11'd3, 120, 40);
    run_phase(11'd2047, 150, 50);
    run_phase('0, 60, 40);
    run_phase(11'd64, 200, 45);
    run_phase(11'd1, 60, 40);
    run_phase(11'd700, 150, 50);
    run_phase(11'd17, 150, 45);
    run_phase(11'd1024, 200, 35);
    run_phase(CFG_W'($urandom_range(0, 2047)), 160, 45);

    in_valid <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
    // stray results after the last one would be caught here
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d results checked over %0d blocks_in_use settings in %0d cycles",
             sb.n_checked, n_settings, cycle_count);
    $display("  %0d blocks handed out or found, %0d refused on full disk, %0d unmapped",
             sb.n_granted, sb.n_disk_full, sb.n_unmapped);
    if (sb.errors == 0 && sb.owed_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== swap_block_allocator_top.f =====
hdl/sba_pkg.sv
hdl/sba_ram.sv
hdl/sba_rem.sv
hdl/swap_block_allocator_top.sv
tb/testbench.sv
